>>> hdl/complex_arithmetic_unit_macros.svh
// Assertion macros used by the checker file.
`ifndef COMPLEX_ARITHMETIC_UNIT_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_MACROS_SVH

// Checks a property on every rising clock edge. The check is off while reset is asserted.
`define CAU_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define CAU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> hdl/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg
// Types, widths and helper functions of the complex arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cau_pkg;

  localparam int DATA_WIDTH = 16;
  localparam int FRAC_BITS  = 8;

  localparam int PW  = 2 * DATA_WIDTH;                 // full product width
  localparam int QB  = DATA_WIDTH + 1;                 // quotient bits developed
  localparam int NW  = PW + 1 + FRAC_BITS;             // scaled numerator width
  localparam int DVW = ((PW + QB > NW) ? (PW + QB) : NW) + 1;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_SAT  = 2'd1,
    ST_DIV0 = 2'd2,
    ST_RSVD = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic signed [DATA_WIDTH-1:0] a_real;
    logic signed [DATA_WIDTH-1:0] a_imag;
    logic signed [DATA_WIDTH-1:0] b_real;
    logic signed [DATA_WIDTH-1:0] b_imag;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] r_real;
    logic signed [DATA_WIDTH-1:0] r_imag;
    logic [1:0]                   status;
  } out_t;

  // Work record that travels down the divider stages.
  typedef struct packed {
    logic                         is_div;
    logic                         div0;
    logic signed [DATA_WIDTH-1:0] res_re;
    logic signed [DATA_WIDTH-1:0] res_im;
    status_e                      st;
    logic                         neg_re;
    logic                         neg_im;
    logic                         ovf_re;
    logic                         ovf_im;
    logic [DVW-1:0]               rem_re;
    logic [DVW-1:0]               rem_im;
    logic [QB-1:0]                q_re;
    logic [QB-1:0]                q_im;
    logic [PW-1:0]                dv;
  } pipe_t;

  typedef struct packed {
    logic                         sat;
    logic signed [DATA_WIDTH-1:0] val;
  } sat_t;

  localparam logic signed [PW:0] SAT_MAX = (PW+1)'((65'sd1 <<< (DATA_WIDTH-1)) - 65'sd1);
  localparam logic signed [PW:0] SAT_MIN = -SAT_MAX - (PW+1)'(1);

  function automatic sat_t clamp(input logic signed [PW:0] x);
    sat_t r;
    r.sat = 1'b1;
    if (x > SAT_MAX) begin
      r.val = DATA_WIDTH'(SAT_MAX);
    end else if (x < SAT_MIN) begin
      r.val = DATA_WIDTH'(SAT_MIN);
    end else begin
      r.sat = 1'b0;
      r.val = DATA_WIDTH'(x);
    end
    return r;
  endfunction

endpackage

>>> hdl/cau_front.sv
// ----------------------------------------------------------------------------
// cau_front
// Two pipeline stages: partial products, then sums, rescaling and divider setup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  cau_pkg::in_t  data_i,
  output logic          valid_o,
  output cau_pkg::pipe_t pipe_o
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PW;

  // Stage 1 registers.
  logic                 v1_q;
  logic [1:0]           op_q;
  logic                 bzero_q;
  logic signed [W:0]    as_q;
  logic signed [W:0]    ai_q;
  logic signed [PW-1:0] p_arbr_q, p_aibi_q, p_arbi_q, p_aibr_q, p_brbr_q, p_bibi_q;

  // Stage 2 registers.
  logic           v2_q;
  cau_pkg::pipe_t pipe_q;
  cau_pkg::pipe_t pipe_d;

  logic signed [W:0] as_d, ai_d;

  always_comb begin
    if (data_i.opcode == cau_pkg::OP_SUB) begin
      as_d = (W+1)'(data_i.a_real) - (W+1)'(data_i.b_real);
      ai_d = (W+1)'(data_i.a_imag) - (W+1)'(data_i.b_imag);
    end else begin
      as_d = (W+1)'(data_i.a_real) + (W+1)'(data_i.b_real);
      ai_d = (W+1)'(data_i.a_imag) + (W+1)'(data_i.b_imag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      op_q     <= data_i.opcode;
      bzero_q  <= (data_i.b_real == '0) && (data_i.b_imag == '0);
      as_q     <= as_d;
      ai_q     <= ai_d;
      p_arbr_q <= PW'(data_i.a_real) * PW'(data_i.b_real);
      p_aibi_q <= PW'(data_i.a_imag) * PW'(data_i.b_imag);
      p_arbi_q <= PW'(data_i.a_real) * PW'(data_i.b_imag);
      p_aibr_q <= PW'(data_i.a_imag) * PW'(data_i.b_real);
      p_brbr_q <= PW'(data_i.b_real) * PW'(data_i.b_real);
      p_bibi_q <= PW'(data_i.b_imag) * PW'(data_i.b_imag);
    end
  end

  logic signed [PW:0]          mre, mim, nre, nim, xre, xim;
  logic [PW:0]                 mag_re, mag_im;
  logic [PW-1:0]               dsum;
  logic [cau_pkg::DVW-1:0]     dlim;
  cau_pkg::sat_t               cre, cim;

  always_comb begin
    mre  = (PW+1)'(p_arbr_q) - (PW+1)'(p_aibi_q);
    mim  = (PW+1)'(p_arbi_q) + (PW+1)'(p_aibr_q);
    nre  = (PW+1)'(p_arbr_q) + (PW+1)'(p_aibi_q);
    nim  = (PW+1)'(p_aibr_q) - (PW+1)'(p_arbi_q);
    dsum = PW'(p_brbr_q) + PW'(p_bibi_q);
    mag_re = nre[PW] ? (PW+1)'(-nre) : (PW+1)'(nre);
    mag_im = nim[PW] ? (PW+1)'(-nim) : (PW+1)'(nim);
    // Products are floored back to the operand format by an arithmetic shift.
    if (op_q == cau_pkg::OP_MUL) begin
      xre = mre >>> cau_pkg::FRAC_BITS;
      xim = mim >>> cau_pkg::FRAC_BITS;
    end else begin
      xre = (PW+1)'(as_q);
      xim = (PW+1)'(ai_q);
    end
    cre = cau_pkg::clamp(xre);
    cim = cau_pkg::clamp(xim);
    dlim = cau_pkg::DVW'(dsum) << cau_pkg::QB;

    pipe_d.is_div = (op_q == cau_pkg::OP_DIV);
    pipe_d.div0   = bzero_q;
    pipe_d.res_re = cre.val;
    pipe_d.res_im = cim.val;
    pipe_d.st     = (cre.sat || cim.sat) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    pipe_d.neg_re = nre[PW];
    pipe_d.neg_im = nim[PW];
    pipe_d.rem_re = cau_pkg::DVW'(mag_re) << cau_pkg::FRAC_BITS;
    pipe_d.rem_im = cau_pkg::DVW'(mag_im) << cau_pkg::FRAC_BITS;
    // A quotient that needs more bits than the divider develops saturates anyway.
    pipe_d.ovf_re = (pipe_d.rem_re >= dlim);
    pipe_d.ovf_im = (pipe_d.rem_im >= dlim);
    pipe_d.q_re   = '0;
    pipe_d.q_im   = '0;
    pipe_d.dv     = dsum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en_i) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q <= pipe_d;
    end
  end

  assign valid_o = v2_q;
  assign pipe_o  = pipe_q;

endmodule

>>> hdl/cau_divider.sv
// ----------------------------------------------------------------------------
// cau_divider
// Restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cau_divider (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  cau_pkg::pipe_t pipe_i,
  output logic           valid_o,
  output cau_pkg::pipe_t pipe_o
);

  localparam int QB  = cau_pkg::QB;
  localparam int DVW = cau_pkg::DVW;

  logic           vld_q [QB];
  cau_pkg::pipe_t stg_q [QB];

  for (genvar k = 0; k < QB; k++) begin : g_stage
    cau_pkg::pipe_t src;
    logic           src_v;
    cau_pkg::pipe_t nxt;
    logic [DVW-1:0] dsh;

    if (k == 0) begin : g_first
      assign src   = pipe_i;
      assign src_v = valid_i;
    end else begin : g_next
      assign src   = stg_q[k-1];
      assign src_v = vld_q[k-1];
    end

    always_comb begin
      nxt = src;
      dsh = DVW'(src.dv) << (QB - 1 - k);
      if (src.rem_re >= dsh) begin
        nxt.rem_re            = src.rem_re - dsh;
        nxt.q_re[QB - 1 - k] = 1'b1;
      end
      if (src.rem_im >= dsh) begin
        nxt.rem_im            = src.rem_im - dsh;
        nxt.q_im[QB - 1 - k] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= src_v;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        stg_q[k] <= nxt;
      end
    end
  end

  assign valid_o = vld_q[QB-1];
  assign pipe_o  = stg_q[QB-1];

endmodule

>>> hdl/complex_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Pipelined complex add, subtract, multiply and divide on signed Q8.8 parts.
// ----------------------------------------------------------------------------
// The unit accepts one beat per clock while in_ready_o is high and returns one
// result beat per input beat, in order. Every operation passes through the same
// DATA_WIDTH + 4 register stages (20 at 16 bits): one stage of partial products,
// one of sums and rescaling, one restoring-divider stage per quotient bit
// (DATA_WIDTH + 1 of them), and the output register. The whole pipe advances
// whenever the output register is empty or being drained, so in_ready_o falls
// only while a result waits and out_ready_i is low.
`timescale 1ns / 1ps

module complex_arithmetic_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  cau_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output cau_pkg::out_t out_data_o
);

  localparam int W  = cau_pkg::DATA_WIDTH;
  localparam int PW = cau_pkg::PW;

  logic           en;
  logic           f_valid, d_valid;
  cau_pkg::pipe_t f_pipe, d_pipe;

  logic           out_valid_q;
  cau_pkg::out_t  out_q, out_d;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  cau_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .valid_o (f_valid),
    .pipe_o  (f_pipe)
  );

  cau_divider u_divider (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f_valid),
    .pipe_i  (f_pipe),
    .valid_o (d_valid),
    .pipe_o  (d_pipe)
  );

  logic signed [PW:0] qre, qim;
  cau_pkg::sat_t      cre, cim;
  logic               sre, sim;

  always_comb begin
    qre = d_pipe.neg_re ? -(PW+1)'(d_pipe.q_re) : (PW+1)'(d_pipe.q_re);
    qim = d_pipe.neg_im ? -(PW+1)'(d_pipe.q_im) : (PW+1)'(d_pipe.q_im);
    cre = cau_pkg::clamp(qre);
    cim = cau_pkg::clamp(qim);
    // An oversized quotient clamps to the bound that matches its sign.
    if (d_pipe.ovf_re) begin
      cre.val = d_pipe.neg_re ? W'(cau_pkg::SAT_MIN) : W'(cau_pkg::SAT_MAX);
    end
    if (d_pipe.ovf_im) begin
      cim.val = d_pipe.neg_im ? W'(cau_pkg::SAT_MIN) : W'(cau_pkg::SAT_MAX);
    end
    sre = cre.sat || d_pipe.ovf_re;
    sim = cim.sat || d_pipe.ovf_im;

    if (!d_pipe.is_div) begin
      out_d.r_real = d_pipe.res_re;
      out_d.r_imag = d_pipe.res_im;
      out_d.status = d_pipe.st;
    end else if (d_pipe.div0) begin
      out_d.r_real = '0;
      out_d.r_imag = '0;
      out_d.status = cau_pkg::ST_DIV0;
    end else begin
      out_d.r_real = cre.val;
      out_d.r_imag = cim.val;
      out_d.status = (sre || sim) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= d_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> hdl/cau_checker.sv
// ----------------------------------------------------------------------------
// cau_checker
// Port-level checks of the complex arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "complex_arithmetic_unit_macros.svh"

module cau_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_ready_o,
  input cau_pkg::in_t  in_data_i,
  input logic          out_valid_o,
  input logic          out_ready_i,
  input cau_pkg::out_t out_data_o
);

  // A result beat waiting for the sink holds steady.
  `CAU_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result beat changed while stalled")

  // The unit only stalls its input while a result is held back.
  `CAU_ASSERT(a_ready, in_ready_o == (!out_valid_o || out_ready_i), "input ready does not follow output stall")

  // The reserved status code never appears.
  `CAU_ASSERT(a_status, out_valid_o |-> out_data_o.status != cau_pkg::ST_RSVD, "reserved status code")

  // A divide by zero reports zero parts.
  `CAU_ASSERT(a_div0, out_valid_o && out_data_o.status == cau_pkg::ST_DIV0 |-> out_data_o.r_real == '0 && out_data_o.r_imag == '0, "nonzero parts on divide by zero")

  // No result leaves while in reset.
  `CAU_ASSERT_ALWAYS(a_rst, !rst_ni |-> !out_valid_o, "output valid during reset")

endmodule

bind complex_arithmetic_unit cau_checker u_cau_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);
